// ----- rtl/dle_pkg.sv -----
// Shared types, constants, oscillator tables and step program for the energy loss block.
package dle_pkg;

	localparam int NumOsc     = 12;
	localparam int OscTable   = 12;
	localparam int NumOscUsed = (NumOsc < OscTable) ? NumOsc : OscTable;
	localparam int OscW       = $clog2(OscTable);

	localparam int MemDepth = 9;
	localparam int MemAw    = $clog2(MemDepth);
	localparam int PcW      = 5;

	localparam logic [PcW-1:0] PcLoop    = PcW'(5);
	localparam logic [PcW-1:0] PcQ       = PcW'(11);
	localparam logic [PcW-1:0] PcLoopEnd = PcW'(18);
	localparam logic [PcW-1:0] PcDen     = PcW'(22);
	localparam logic [PcW-1:0] PcLast    = PcW'(23);

	localparam logic [63:0] DblTwo = 64'h4000_0000_0000_0000;
	localparam logic [63:0] DblNaN = 64'h7FF8_0000_0000_0000;

	localparam logic [63:0] OscStrength [OscTable] = '{
		$realtobits(0.1066898493), $realtobits(0.0121545398), $realtobits(0.0486181592),
		$realtobits(0.0229585752), $realtobits(0.0810302653), $realtobits(0.1350504422),
		$realtobits(0.1620605306), $realtobits(0.2093281854), $realtobits(0.1958231412),
		$realtobits(0.3781412382), $realtobits(0.4861815919), $realtobits(0.2471423092)
	};

	localparam logic [63:0] OscDamping [OscTable] = '{
		$realtobits(0.003674921), $realtobits(0.0367492098), $realtobits(0.0698234986),
		$realtobits(0.0845231826), $realtobits(0.1469968393), $realtobits(0.3307428883),
		$realtobits(0.3674920982), $realtobits(0.2204952589), $realtobits(0.2645943107),
		$realtobits(0.7349841963), $realtobits(1.0289778748), $realtobits(0.9554794552)
	};

	localparam logic [63:0] OscEnergy [OscTable] = '{
		$realtobits(0.0), $realtobits(0.1139225504), $realtobits(0.1506717602),
		$realtobits(0.194770812), $realtobits(0.3002410442), $realtobits(0.4409905178),
		$realtobits(0.5144889374), $realtobits(0.7827581691), $realtobits(1.0841016896),
		$realtobits(1.4148445779), $realtobits(2.3152002184), $realtobits(3.6749209815)
	};

	typedef enum logic [1:0] {FOP_ADD, FOP_SUB, FOP_MUL, FOP_DIV} fop_t;

	// scratch entries first, they map straight onto memory addresses
	typedef enum logic [4:0] {
		SRC_HK, SRC_W2, SRC_R, SRC_D, SRC_T, SRC_U, SRC_Q, SRC_S1, SRC_S2,
		SRC_K, SRC_W, SRC_EB, SRC_TWO, SRC_ZERO, SRC_OE, SRC_OG, SRC_OA
	} src_t;

	typedef struct packed {
		fop_t op;
		src_t a;
		src_t b;
		src_t dst;
	} step_t;

	typedef struct packed {
		logic        start;
		fop_t        op;
		logic [63:0] a;
		logic [63:0] b;
	} fpu_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] value;
	} fpu_rsp_t;

	typedef struct packed {
		logic        valid;
		logic [63:0] value;
		logic        invalid;
	} res_t;

	function automatic step_t prog_f(input logic [PcW-1:0] pc);
		step_t s;
		unique case (pc)
			5'd0:    s = '{FOP_MUL, SRC_K,    SRC_K,    SRC_T};
			5'd1:    s = '{FOP_DIV, SRC_T,    SRC_TWO,  SRC_HK};
			5'd2:    s = '{FOP_MUL, SRC_W,    SRC_W,    SRC_W2};
			5'd3:    s = '{FOP_ADD, SRC_ZERO, SRC_ZERO, SRC_S1};
			5'd4:    s = '{FOP_ADD, SRC_ZERO, SRC_ZERO, SRC_S2};
			5'd5:    s = '{FOP_ADD, SRC_OE,   SRC_HK,   SRC_R};
			5'd6:    s = '{FOP_MUL, SRC_R,    SRC_R,    SRC_T};
			5'd7:    s = '{FOP_SUB, SRC_W2,   SRC_T,    SRC_D};
			5'd8:    s = '{FOP_MUL, SRC_OG,   SRC_OG,   SRC_T};
			5'd9:    s = '{FOP_MUL, SRC_W2,   SRC_T,    SRC_T};
			5'd10:   s = '{FOP_MUL, SRC_D,    SRC_D,    SRC_U};
			5'd11:   s = '{FOP_ADD, SRC_U,    SRC_T,    SRC_Q};
			5'd12:   s = '{FOP_MUL, SRC_OA,   SRC_D,    SRC_T};
			5'd13:   s = '{FOP_DIV, SRC_T,    SRC_Q,    SRC_T};
			5'd14:   s = '{FOP_ADD, SRC_S1,   SRC_T,    SRC_S1};
			5'd15:   s = '{FOP_MUL, SRC_OA,   SRC_OG,   SRC_T};
			5'd16:   s = '{FOP_MUL, SRC_T,    SRC_W,    SRC_T};
			5'd17:   s = '{FOP_DIV, SRC_T,    SRC_Q,    SRC_T};
			5'd18:   s = '{FOP_ADD, SRC_S2,   SRC_T,    SRC_S2};
			5'd19:   s = '{FOP_SUB, SRC_EB,   SRC_S1,   SRC_T};
			5'd20:   s = '{FOP_MUL, SRC_T,    SRC_T,    SRC_T};
			5'd21:   s = '{FOP_MUL, SRC_S2,   SRC_S2,   SRC_U};
			5'd22:   s = '{FOP_ADD, SRC_T,    SRC_U,    SRC_Q};
			default: s = '{FOP_DIV, SRC_S2,   SRC_Q,    SRC_T};
		endcase
		return s;
	endfunction

endpackage

// ----- rtl/dle_fpu.sv -----
// Shared multi-cycle binary64 add/sub/mul/div unit, round to nearest even.
module dle_fpu (
	input  logic               clk,
	input  logic               arst_n,
	input  dle_pkg::fpu_req_t  req,
	output dle_pkg::fpu_rsp_t  rsp
);
	import dle_pkg::*;

	typedef enum logic [2:0] {F_IDLE, F_MUL, F_PRE, F_DIV, F_NORM, F_RND} fst_t;

	fst_t               state_q;
	logic               done_q;
	logic [63:0]        res_q;
	logic               sign_q;
	logic               zpos_q;
	logic signed [13:0] e_q;
	logic signed [13:0] ea_q;
	logic signed [13:0] eb_q;
	logic [109:0]       m_q;
	logic [52:0]        ma_q;
	logic [52:0]        mb_q;
	logic [53:0]        rem_q;
	logic [55:0]        quo_q;
	logic [5:0]         cnt_q;

	logic               sa, sb, sx, eff_sub, swap;
	logic [10:0]        fa, fb, big_e, sml_e, dif;
	logic               a_zero, b_zero, a_inf, b_inf, a_nan, b_nan;
	logic [52:0]        ma, mb, big_m, sml_m;
	logic signed [13:0] ea, eb;
	logic [109:0]       sml_x, big_x, sh, al, sum;
	logic               lost;
	logic [26:0]        pa, pb;
	logic [53:0]        pp;
	logic [109:0]       ppx;
	logic               ge;
	logic [53:0]        diff;
	logic [52:0]        rm;
	logic               inc;
	logic [53:0]        rs;
	logic [52:0]        mant2;
	logic signed [13:0] e2;

	always_comb begin
		sa      = req.a[63];
		sb      = req.b[63] ^ (req.op == FOP_SUB);
		sx      = req.a[63] ^ req.b[63];
		fa      = req.a[62:52];
		fb      = req.b[62:52];
		a_zero  = (req.a[62:0] == '0);
		b_zero  = (req.b[62:0] == '0);
		a_inf   = (fa == 11'h7FF) && (req.a[51:0] == '0);
		b_inf   = (fb == 11'h7FF) && (req.b[51:0] == '0);
		a_nan   = (fa == 11'h7FF) && (req.a[51:0] != '0);
		b_nan   = (fb == 11'h7FF) && (req.b[51:0] != '0);
		ma      = {fa != 11'd0, req.a[51:0]};
		mb      = {fb != 11'd0, req.b[51:0]};
		ea      = {3'b000, (fa == 11'd0) ? 11'd1 : fa};
		eb      = {3'b000, (fb == 11'd0) ? 11'd1 : fb};
		eff_sub = sa ^ sb;
		swap    = req.b[62:0] > req.a[62:0];
		big_m   = swap ? mb : ma;
		sml_m   = swap ? ma : mb;
		big_e   = swap ? eb[10:0] : ea[10:0];
		sml_e   = swap ? ea[10:0] : eb[10:0];
		dif     = big_e - sml_e;
		sml_x   = {1'b0, sml_m, 56'd0};
		big_x   = {1'b0, big_m, 56'd0};
		if (dif >= 11'd110) begin
			sh   = '0;
			lost = (sml_x != '0);
		end else begin
			sh   = sml_x >> dif;
			lost = ((sh << dif) != sml_x);
		end
		// everything below bit 1 folds into one sticky bit
		al  = {sh[109:1], sh[0] | lost};
		sum = eff_sub ? (big_x - al) : (big_x + al);
	end

	always_comb begin
		pa = cnt_q[1] ? {1'b0, ma_q[52:27]} : ma_q[26:0];
		pb = cnt_q[0] ? {1'b0, mb_q[52:27]} : mb_q[26:0];
		pp = pa * pb;
		unique case (cnt_q[1:0])
			2'd0:    ppx = {56'd0, pp} << 3;
			2'd3:    ppx = {56'd0, pp} << 57;
			default: ppx = {56'd0, pp} << 30;
		endcase
	end

	always_comb begin
		ge   = rem_q >= {1'b0, mb_q};
		diff = ge ? (rem_q - {1'b0, mb_q}) : rem_q;
	end

	always_comb begin
		rm    = m_q[108:56];
		inc   = m_q[55] & ((|m_q[54:0]) | rm[0]);
		rs    = {1'b0, rm} + {53'd0, inc};
		mant2 = rs[53] ? rs[53:1] : rs[52:0];
		e2    = rs[53] ? (e_q + 14'sd1) : e_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			done_q  <= 1'b0;
			res_q   <= '0;
			sign_q  <= 1'b0;
			zpos_q  <= 1'b0;
			e_q     <= '0;
			ea_q    <= '0;
			eb_q    <= '0;
			m_q     <= '0;
			ma_q    <= '0;
			mb_q    <= '0;
			rem_q   <= '0;
			quo_q   <= '0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				F_IDLE: begin
					if (req.start) begin
						unique case (req.op)
							FOP_ADD, FOP_SUB: begin
								if (a_nan || b_nan || (a_inf && b_inf && eff_sub)) begin
									res_q  <= DblNaN;
									done_q <= 1'b1;
								end else if (a_inf) begin
									res_q  <= {sa, 11'h7FF, 52'd0};
									done_q <= 1'b1;
								end else if (b_inf) begin
									res_q  <= {sb, 11'h7FF, 52'd0};
									done_q <= 1'b1;
								end else begin
									m_q     <= sum;
									e_q     <= {3'b000, big_e};
									sign_q  <= swap ? sb : sa;
									zpos_q  <= eff_sub;
									state_q <= F_NORM;
								end
							end
							FOP_MUL: begin
								if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) begin
									res_q  <= DblNaN;
									done_q <= 1'b1;
								end else if (a_inf || b_inf) begin
									res_q  <= {sx, 11'h7FF, 52'd0};
									done_q <= 1'b1;
								end else if (a_zero || b_zero) begin
									res_q  <= {sx, 63'd0};
									done_q <= 1'b1;
								end else begin
									ma_q    <= ma;
									mb_q    <= mb;
									m_q     <= '0;
									cnt_q   <= '0;
									e_q     <= ea + eb - 14'sd1022;
									sign_q  <= sx;
									zpos_q  <= 1'b0;
									state_q <= F_MUL;
								end
							end
							FOP_DIV: begin
								if (a_nan || b_nan || (a_inf && b_inf) || (a_zero && b_zero)) begin
									res_q  <= DblNaN;
									done_q <= 1'b1;
								end else if (a_inf || b_zero) begin
									res_q  <= {sx, 11'h7FF, 52'd0};
									done_q <= 1'b1;
								end else if (a_zero || b_inf) begin
									res_q  <= {sx, 63'd0};
									done_q <= 1'b1;
								end else begin
									ma_q    <= ma;
									mb_q    <= mb;
									ea_q    <= ea;
									eb_q    <= eb;
									sign_q  <= sx;
									zpos_q  <= 1'b0;
									state_q <= F_PRE;
								end
							end
							default: begin
								res_q  <= DblNaN;
								done_q <= 1'b1;
							end
						endcase
					end
				end
				F_MUL: begin
					m_q   <= m_q + ppx;
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q[1:0] == 2'd3) begin
						state_q <= F_NORM;
					end
				end
				F_PRE: begin
					// bring subnormal divide operands to a leading one
					if (!ma_q[52]) begin
						ma_q <= {ma_q[51:0], 1'b0};
						ea_q <= ea_q - 14'sd1;
					end
					if (!mb_q[52]) begin
						mb_q <= {mb_q[51:0], 1'b0};
						eb_q <= eb_q - 14'sd1;
					end
					if (ma_q[52] && mb_q[52]) begin
						rem_q   <= {1'b0, ma_q};
						quo_q   <= '0;
						cnt_q   <= '0;
						e_q     <= ea_q - eb_q + 14'sd1023;
						state_q <= F_DIV;
					end
				end
				F_DIV: begin
					rem_q <= {diff[52:0], 1'b0};
					quo_q <= {quo_q[54:0], ge};
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd55) begin
						m_q     <= {1'b0, quo_q[54:0], ge, 52'd0, diff != '0};
						state_q <= F_NORM;
					end
				end
				F_NORM: begin
					priority if (m_q[109]) begin
						m_q <= {1'b0, m_q[109:2], m_q[1] | m_q[0]};
						e_q <= e_q + 14'sd1;
					end else if (e_q < -14'sd120) begin
						m_q <= {109'd0, m_q != '0};
						e_q <= 14'sd1;
					end else if (e_q < 14'sd1) begin
						m_q <= {1'b0, m_q[109:2], m_q[1] | m_q[0]};
						e_q <= e_q + 14'sd1;
					end else if (!m_q[108] && (e_q > 14'sd1) && (m_q != '0)) begin
						m_q <= {m_q[108:0], 1'b0};
						e_q <= e_q - 14'sd1;
					end else begin
						state_q <= F_RND;
					end
				end
				F_RND: begin
					priority if (m_q == '0) begin
						res_q <= {sign_q & ~zpos_q, 63'd0};
					end else if (e2 >= 14'sd2047) begin
						res_q <= {sign_q, 11'h7FF, 52'd0};
					end else begin
						res_q <= {sign_q, mant2[52] ? e2[10:0] : 11'd0, mant2[51:0]};
					end
					done_q  <= 1'b1;
					state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	assign rsp.done  = done_q;
	assign rsp.value = res_q;

endmodule

// ----- rtl/dle_seq.sv -----
// Step sequencer with scratch memory driving the shared floating point unit.
module dle_seq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [62:0]        k,
	input  logic [62:0]        w,
	input  logic [62:0]        eb,
	output logic               ready,
	output dle_pkg::fpu_req_t  req,
	input  dle_pkg::fpu_rsp_t  rsp,
	output dle_pkg::res_t      res,
	input  logic               res_ack
);
	import dle_pkg::*;

	typedef enum logic [2:0] {S_IDLE, S_READ, S_EXEC, S_WAIT, S_DONE} st_t;

	st_t              state_q;
	logic [PcW-1:0]   pc_q;
	logic [OscW-1:0]  osc_q;
	logic [62:0]      k_q;
	logic [62:0]      w_q;
	logic [63:0]      a_q;
	logic [63:0]      b_q;
	logic [63:0]      val_q;
	logic             inv_q;
	logic [63:0]      mem_q [MemDepth];

	step_t            step;
	logic [63:0]      ca, cb;

	function automatic logic [63:0] const_f(input src_t s, input logic [62:0] kk,
		input logic [62:0] ww, input logic [62:0] bb, input logic [OscW-1:0] o);
		logic [63:0] v;
		unique case (s)
			SRC_K:    v = {1'b0, kk};
			SRC_W:    v = {1'b0, ww};
			SRC_EB:   v = {1'b0, bb};
			SRC_TWO:  v = DblTwo;
			SRC_OE:   v = OscEnergy[o];
			SRC_OG:   v = OscDamping[o];
			SRC_OA:   v = OscStrength[o];
			default:  v = '0;
		endcase
		return v;
	endfunction

	always_comb begin
		step = prog_f(pc_q);
		ca   = const_f(step.a, k_q, w_q, eb, osc_q);
		cb   = const_f(step.b, k_q, w_q, eb, osc_q);
	end

	always_ff @(posedge clk) begin
		if (state_q == S_READ) begin
			a_q <= (step.a <= SRC_S2) ? mem_q[step.a[MemAw-1:0]] : ca;
			b_q <= (step.b <= SRC_S2) ? mem_q[step.b[MemAw-1:0]] : cb;
		end
		if ((state_q == S_WAIT) && rsp.done) begin
			mem_q[step.dst[MemAw-1:0]] <= rsp.value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pc_q    <= '0;
			osc_q   <= '0;
			k_q     <= '0;
			w_q     <= '0;
			val_q   <= '0;
			inv_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						k_q     <= k;
						w_q     <= w;
						pc_q    <= '0;
						osc_q   <= '0;
						state_q <= S_READ;
					end
				end
				S_READ: state_q <= S_EXEC;
				S_EXEC: state_q <= S_WAIT;
				S_WAIT: begin
					if (rsp.done) begin
						priority if (((pc_q == PcQ) || (pc_q == PcDen)) &&
								(rsp.value[62:0] == '0)) begin
							val_q   <= '0;
							inv_q   <= 1'b1;
							state_q <= S_DONE;
						end else if (pc_q == PcLast) begin
							if (rsp.value[62:52] == 11'h7FF) begin
								val_q <= '0;
								inv_q <= 1'b1;
							end else begin
								val_q <= rsp.value;
								inv_q <= 1'b0;
							end
							state_q <= S_DONE;
						end else if ((pc_q == PcLoopEnd) &&
								(osc_q != OscW'(NumOscUsed - 1))) begin
							osc_q   <= osc_q + OscW'(1);
							pc_q    <= PcLoop;
							state_q <= S_READ;
						end else begin
							pc_q    <= pc_q + PcW'(1);
							state_q <= S_READ;
						end
					end
				end
				S_DONE: begin
					if (res_ack) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign ready       = (state_q == S_IDLE);
	assign req.start   = (state_q == S_EXEC);
	assign req.op      = step.op;
	assign req.a       = a_q;
	assign req.b       = b_q;
	assign res.valid   = (state_q == S_DONE);
	assign res.value   = val_q;
	assign res.invalid = inv_q;

endmodule

// ----- rtl/drude_lorentz_energy_loss_top.sv -----
// Top level: Drude-Lorentz energy loss function evaluator with stream ports.
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid/s_axis_tready    k, omega words
//  m_axis    out  m_axis_tvalid/m_axis_tready    loss word, invalid flag
//  cfg       in   cfg_valid/cfg_ready            background permittivity
//
// A word runs up to 178 operations through the one shared binary64 unit
// (multiply and divide iterate, add and normalize one bit per cycle).
// Reset returns to idle with permittivity 1.0.
// A finished result waits in the output register; a new word may be accepted meanwhile.
// Configuration is taken only while no word is being computed.
module drude_lorentz_energy_loss_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [127:0] s_axis_tdata,   // [62:0] momentum_transfer, [125:63] energy_loss
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [63:0]  m_axis_tdata,   // [63:0] loss_function
	output logic         m_axis_tuser,   // [0] invalid
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [62:0]  cfg_data
);
	import dle_pkg::*;

	logic [62:0] perm_q;
	logic        out_valid_q;
	logic [63:0] out_data_q;
	logic        out_user_q;
	logic        seq_ready;
	logic        res_ack;
	fpu_req_t    req;
	fpu_rsp_t    rsp;
	res_t        res;

	dle_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (s_axis_tvalid & seq_ready),
		.k       (s_axis_tdata[62:0]),
		.w       (s_axis_tdata[125:63]),
		.eb      (perm_q),
		.ready   (seq_ready),
		.req     (req),
		.rsp     (rsp),
		.res     (res),
		.res_ack (res_ack)
	);

	dle_fpu u_fpu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	assign res_ack = res.valid & (~out_valid_q | m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			perm_q      <= 63'h3FF0_0000_0000_0000;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
			out_user_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				perm_q <= cfg_data;
			end
			if (res_ack) begin
				out_valid_q <= 1'b1;
				out_data_q  <= res.value;
				out_user_q  <= res.invalid;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign cfg_ready     = seq_ready;
	assign s_axis_tready = seq_ready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;

endmodule

// ----- sim/energy_loss_checker.sv -----
// Checker for the energy loss block: predicts each loss word and compares it with the output.
module energy_loss_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic [127:0] s_axis_tdata,   // [62:0] momentum_transfer, [125:63] energy_loss
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [63:0]  m_axis_tdata,   // [63:0] loss_function
	input  logic         m_axis_tuser,   // [0] invalid
	input  logic         cfg_valid,
	input  logic         cfg_ready,
	input  logic [62:0]  cfg_data,
	output int           fail_count,
	output int           pending
);
	import dle_pkg::*;

	typedef struct packed {
		logic [63:0] loss;
		logic        invalid;
	} loss_word_t;

	loss_word_t  loss_queue[$];
	logic [62:0] permittivity;

	function automatic loss_word_t loss_function_f(input logic [62:0] k_bits,
			input logic [62:0] w_bits, input logic [62:0] eb_bits);
		real k, w, eb, hk, w2, s1, s2, r, d, g, q, e1, den, res;
		logic bad;
		loss_word_t o;
		k   = $bitstoreal({1'b0, k_bits});
		w   = $bitstoreal({1'b0, w_bits});
		eb  = $bitstoreal({1'b0, eb_bits});
		hk  = (k * k) / 2.0;
		w2  = w * w;
		s1  = 0.0;
		s2  = 0.0;
		bad = 1'b0;
		res = 0.0;
		for (int i = 0; i < NumOscUsed; i++) begin
			r = $bitstoreal(OscEnergy[i]) + hk;
			d = w2 - r * r;
			g = $bitstoreal(OscDamping[i]);
			q = d * d + w2 * (g * g);
			if (q == 0.0) begin
				bad = 1'b1;
				break;
			end
			s1 = s1 + ($bitstoreal(OscStrength[i]) * d) / q;
			s2 = s2 + ($bitstoreal(OscStrength[i]) * g * w) / q;
		end
		if (!bad) begin
			e1  = eb - s1;
			den = e1 * e1 + s2 * s2;
			if (den == 0.0) begin
				bad = 1'b1;
			end else begin
				res = s2 / den;
				if (!((res - res) == 0.0))
					bad = 1'b1;
			end
		end
		o.loss    = bad ? 64'h0 : $realtobits(res);
		o.invalid = bad;
		return o;
	endfunction

	assign pending = loss_queue.size();

	always @(posedge clk or negedge arst_n) begin
		loss_word_t want;
		if (!arst_n) begin
			permittivity = 63'h3FF0_0000_0000_0000;
			fail_count   = 0;
			loss_queue.delete();
		end else begin
			if (cfg_valid && cfg_ready)
				permittivity = cfg_data;
			if (s_axis_tvalid && s_axis_tready)
				loss_queue.push_back(loss_function_f(s_axis_tdata[62:0],
					s_axis_tdata[125:63], permittivity));
			if (m_axis_tvalid && m_axis_tready) begin
				if (loss_queue.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected word: loss %h invalid %b", m_axis_tdata,
							m_axis_tuser);
				end else begin
					want = loss_queue.pop_front();
					if (want.loss !== m_axis_tdata || want.invalid !== m_axis_tuser) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: loss exp %h got %h, invalid exp %b got %b",
								want.loss, m_axis_tdata, want.invalid, m_axis_tuser);
					end
				end
			end
		end
	end

endmodule

// ----- sim/testbench.sv -----
// Testbench top: drives stimulus and configuration into the energy loss block and gives the verdict.
module testbench;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [127:0] s_axis_tdata;   // [62:0] momentum_transfer, [125:63] energy_loss
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [63:0]  m_axis_tdata;   // [63:0] loss_function
	logic         m_axis_tuser;   // [0] invalid
	logic         cfg_valid;
	logic         cfg_ready;
	logic [62:0]  cfg_data;
	int           fail_count;
	int           pending;
	int           send_idle;
	int           recv_idle;
	int           quiet_cycles;

	localparam int QuietLimit = 200000;
	localparam logic [62:0] MaxFinite = 63'h7FEF_FFFF_FFFF_FFFF;
	localparam logic [62:0] PosInf    = 63'h7FF0_0000_0000_0000;
	localparam logic [62:0] QuietNan  = 63'h7FF8_0000_0000_0000;
	localparam logic [62:0] AllOnes   = 63'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [62:0] One       = 63'h3FF0_0000_0000_0000;

	drude_lorentz_energy_loss_top u_top (
		.clk, .arst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
		.m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
		.cfg_valid, .cfg_ready, .cfg_data
	);

	energy_loss_checker u_checker (
		.clk, .arst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
		.m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
		.cfg_valid, .cfg_ready, .cfg_data, .fail_count, .pending
	);

	function automatic logic [62:0] dbl(input real x);
		return 63'($realtobits(x));
	endfunction

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(negedge clk)
		m_axis_tready <= ($urandom_range(99) >= recv_idle);

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
					(cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QuietLimit) begin
				$display("** drude_lorentz_energy_loss_top: FAILED **");
				$finish;
			end
		end
	end

	task automatic send_word(input logic [62:0] k_bits, input logic [62:0] w_bits);
		@(negedge clk);
		while ($urandom_range(99) < send_idle) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {2'b00, w_bits, k_bits};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic drain();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic write_permittivity(input logic [62:0] value);
		drain();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [62:0] random_double();
		logic [62:0] v;
		if ($urandom_range(99) < 75)
			v = dbl($urandom_range(0, 1000000) / 200000.0);
		else
			v = 63'({$urandom, $urandom});
		return v;
	endfunction

	task automatic random_run(input int count);
		for (int i = 0; i < count; i++) begin
			send_word(random_double(), random_double());
			if (i == count / 2 && $urandom_range(1))
				drain();
		end
	endtask

	initial begin
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		m_axis_tready = 1'b0;
		cfg_valid     = 1'b0;
		cfg_data      = '0;
		send_idle     = 31;
		recv_idle     = 65;
		quiet_cycles  = 0;
		arst_n        = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// zero q for the first oscillator, extremes, infinities and NaNs
		send_word(63'h0, 63'h0);
		send_word(63'h0, dbl(0.5));
		send_word(dbl(0.5), 63'h0);
		send_word(dbl(0.3), dbl(0.4409905178));
		send_word(63'h1, 63'h1);
		send_word(MaxFinite, MaxFinite);
		send_word(MaxFinite, dbl(1.0));
		send_word(dbl(1.0), MaxFinite);
		send_word(PosInf, dbl(1.0));
		send_word(dbl(1.0), PosInf);
		send_word(QuietNan, dbl(1.0));
		send_word(AllOnes, AllOnes);
		send_word(dbl(1e-160), dbl(1e-160));
		send_word(dbl(1e150), dbl(1e-3));
		send_word(dbl(2.0), dbl(3.0));
		drain();
		write_permittivity(63'h0);
		send_word(63'h0, dbl(1e-300));
		send_word(dbl(0.1), dbl(0.2));
		write_permittivity(PosInf);
		send_word(dbl(0.1), dbl(0.2));
		write_permittivity(AllOnes);
		send_word(dbl(0.1), dbl(0.2));

		write_permittivity(One);
		random_run(100);
		write_permittivity(63'h0);
		random_run(100);
		drain();
		send_idle = 65;
		recv_idle = 31;
		write_permittivity(MaxFinite);
		random_run(60);
		write_permittivity(dbl($urandom_range(1000, 10000) / 1000.0));
		random_run(100);
		drain();
		send_idle = 0;
		recv_idle = 0;
		write_permittivity(PosInf);
		random_run(30);
		write_permittivity(AllOnes);
		random_run(20);
		write_permittivity(63'({$urandom, $urandom}));
		random_run(90);
		drain();

		repeat (200) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("** drude_lorentz_energy_loss_top: PASSED **");
		else
			$display("** drude_lorentz_energy_loss_top: FAILED **");
		$finish;
	end

endmodule
